@@ hdl/lcdnib_pkg.sv @@
`default_nettype none
package lcdnib_pkg;

    localparam int unsigned PC_W       = 6;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned PULSE_W    = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0] FIRST_INIT_WAIT_US = 16'd5000;
    localparam logic [7:0]        CMD_FUNCTION_SET   = 8'h28;
    localparam logic [7:0]        CMD_DISPLAY_OFF    = 8'h08;
    localparam logic [7:0]        CMD_CLEAR          = 8'h01;
    localparam logic [7:0]        ROW0_BASE          = 8'h80;
    localparam logic [7:0]        ROW1_BASE          = 8'hC0;
    localparam logic [3:0]        WAKE_NIBBLE        = 4'h3;
    localparam logic [3:0]        FOUR_BIT_NIBBLE    = 4'h2;

    // program entry points
    localparam logic [PC_W-1:0] PC_INIT  = 6'd0;
    localparam logic [PC_W-1:0] PC_BYTE  = 6'd38;
    localparam logic [PC_W-1:0] PC_CLEAR = 6'd42;

    typedef enum logic [1:0] {
        ACT_INIT   = 2'd0,
        ACT_CURSOR = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_CHAR   = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE   = 3'd0,
        CFG_PWRUP   = 3'd1,
        CFG_CLRWAIT = 3'd2,
        CFG_STEP    = 3'd3,
        CFG_ENTRY   = 3'd4,
        CFG_DISP    = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        NIB_KEEP,
        NIB_HI,
        NIB_LO,
        NIB_WAKE,
        NIB_FOUR
    } t_nib_sel;

    typedef enum logic [2:0] {
        BYTE_OPER,
        BYTE_FSET,
        BYTE_DOFF,
        BYTE_CLR,
        BYTE_ENTRY,
        BYTE_DISP
    } t_byte_sel;

    typedef enum logic [2:0] {
        HOLD_PULSE,
        HOLD_PWRUP,
        HOLD_FIRST,
        HOLD_STEP,
        HOLD_CLEAR
    } t_hold_sel;

    typedef struct packed {
        t_nib_sel  nib;
        t_byte_sel byte_sel;
        logic      en;
        t_hold_sel hold;
        logic      last;
    } t_uword;

    typedef struct packed {
        logic   fire;
        t_uword word;
    } t_ctrl;

    function automatic t_uword mk(t_nib_sel nib, t_byte_sel bsel, logic en,
                                  t_hold_sel hold, logic last);
        t_uword w;
        w.nib      = nib;
        w.byte_sel = bsel;
        w.en       = en;
        w.hold     = hold;
        w.last     = last;
        return w;
    endfunction

    function automatic logic [PC_W-1:0] start_pc(t_action act);
        logic [PC_W-1:0] pc;
        case (act)
            ACT_INIT:  pc = PC_INIT;
            ACT_CLEAR: pc = PC_CLEAR;
            default:   pc = PC_BYTE;
        endcase
        return pc;
    endfunction

    // control store: one word per pin state
    function automatic t_uword ucode(logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            // power-up wait, then wake nibbles 3,3,3 and the 4-bit nibble 2
            6'd0:  w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_PWRUP, 1'b0);
            6'd1:  w = mk(NIB_WAKE, BYTE_OPER,  1'b1, HOLD_PULSE, 1'b0);
            6'd2:  w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_PULSE, 1'b0);
            6'd3:  w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_FIRST, 1'b0);
            6'd4:  w = mk(NIB_WAKE, BYTE_OPER,  1'b1, HOLD_PULSE, 1'b0);
            6'd5:  w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_PULSE, 1'b0);
            6'd6:  w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_STEP,  1'b0);
            6'd7:  w = mk(NIB_WAKE, BYTE_OPER,  1'b1, HOLD_PULSE, 1'b0);
            6'd8:  w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_PULSE, 1'b0);
            6'd9:  w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_STEP,  1'b0);
            6'd10: w = mk(NIB_FOUR, BYTE_OPER,  1'b1, HOLD_PULSE, 1'b0);
            6'd11: w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_PULSE, 1'b0);
            6'd12: w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_STEP,  1'b0);
            // function set
            6'd13: w = mk(NIB_HI,   BYTE_FSET,  1'b1, HOLD_PULSE, 1'b0);
            6'd14: w = mk(NIB_KEEP, BYTE_FSET,  1'b0, HOLD_PULSE, 1'b0);
            6'd15: w = mk(NIB_LO,   BYTE_FSET,  1'b1, HOLD_PULSE, 1'b0);
            6'd16: w = mk(NIB_KEEP, BYTE_FSET,  1'b0, HOLD_PULSE, 1'b0);
            6'd17: w = mk(NIB_KEEP, BYTE_FSET,  1'b0, HOLD_STEP,  1'b0);
            // display off
            6'd18: w = mk(NIB_HI,   BYTE_DOFF,  1'b1, HOLD_PULSE, 1'b0);
            6'd19: w = mk(NIB_KEEP, BYTE_DOFF,  1'b0, HOLD_PULSE, 1'b0);
            6'd20: w = mk(NIB_LO,   BYTE_DOFF,  1'b1, HOLD_PULSE, 1'b0);
            6'd21: w = mk(NIB_KEEP, BYTE_DOFF,  1'b0, HOLD_PULSE, 1'b0);
            6'd22: w = mk(NIB_KEEP, BYTE_DOFF,  1'b0, HOLD_STEP,  1'b0);
            // clear
            6'd23: w = mk(NIB_HI,   BYTE_CLR,   1'b1, HOLD_PULSE, 1'b0);
            6'd24: w = mk(NIB_KEEP, BYTE_CLR,   1'b0, HOLD_PULSE, 1'b0);
            6'd25: w = mk(NIB_LO,   BYTE_CLR,   1'b1, HOLD_PULSE, 1'b0);
            6'd26: w = mk(NIB_KEEP, BYTE_CLR,   1'b0, HOLD_PULSE, 1'b0);
            6'd27: w = mk(NIB_KEEP, BYTE_CLR,   1'b0, HOLD_CLEAR, 1'b0);
            // entry mode
            6'd28: w = mk(NIB_HI,   BYTE_ENTRY, 1'b1, HOLD_PULSE, 1'b0);
            6'd29: w = mk(NIB_KEEP, BYTE_ENTRY, 1'b0, HOLD_PULSE, 1'b0);
            6'd30: w = mk(NIB_LO,   BYTE_ENTRY, 1'b1, HOLD_PULSE, 1'b0);
            6'd31: w = mk(NIB_KEEP, BYTE_ENTRY, 1'b0, HOLD_PULSE, 1'b0);
            6'd32: w = mk(NIB_KEEP, BYTE_ENTRY, 1'b0, HOLD_STEP,  1'b0);
            // display control
            6'd33: w = mk(NIB_HI,   BYTE_DISP,  1'b1, HOLD_PULSE, 1'b0);
            6'd34: w = mk(NIB_KEEP, BYTE_DISP,  1'b0, HOLD_PULSE, 1'b0);
            6'd35: w = mk(NIB_LO,   BYTE_DISP,  1'b1, HOLD_PULSE, 1'b0);
            6'd36: w = mk(NIB_KEEP, BYTE_DISP,  1'b0, HOLD_PULSE, 1'b0);
            6'd37: w = mk(NIB_KEEP, BYTE_DISP,  1'b0, HOLD_STEP,  1'b1);
            // single byte: cursor address or character
            6'd38: w = mk(NIB_HI,   BYTE_OPER,  1'b1, HOLD_PULSE, 1'b0);
            6'd39: w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_PULSE, 1'b0);
            6'd40: w = mk(NIB_LO,   BYTE_OPER,  1'b1, HOLD_PULSE, 1'b0);
            6'd41: w = mk(NIB_KEEP, BYTE_OPER,  1'b0, HOLD_PULSE, 1'b1);
            // clear command with its wait
            6'd42: w = mk(NIB_HI,   BYTE_CLR,   1'b1, HOLD_PULSE, 1'b0);
            6'd43: w = mk(NIB_KEEP, BYTE_CLR,   1'b0, HOLD_PULSE, 1'b0);
            6'd44: w = mk(NIB_LO,   BYTE_CLR,   1'b1, HOLD_PULSE, 1'b0);
            6'd45: w = mk(NIB_KEEP, BYTE_CLR,   1'b0, HOLD_PULSE, 1'b0);
            6'd46: w = mk(NIB_KEEP, BYTE_CLR,   1'b0, HOLD_CLEAR, 1'b1);
            default: w = mk(NIB_KEEP, BYTE_OPER, 1'b0, HOLD_PULSE, 1'b1);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ hdl/lcdnib_seq.sv @@
`default_nettype none
module lcdnib_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire lcdnib_pkg::t_action         i_action,
    input  wire logic                        i_slot_free,
    output logic                             o_busy,
    output lcdnib_pkg::t_ctrl                o_ctrl
);

    logic                        r_busy;
    logic [lcdnib_pkg::PC_W-1:0] r_pc;
    lcdnib_pkg::t_uword          w_word;
    logic                        w_fire;

    assign w_word = lcdnib_pkg::ucode(r_pc);
    assign w_fire = r_busy && i_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= lcdnib_pkg::PC_INIT;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_pc   <= lcdnib_pkg::start_pc(i_action);
        end else if (w_fire) begin
            if (w_word.last) begin
                r_busy <= 1'b0;
            end else begin
                r_pc <= r_pc + {{(lcdnib_pkg::PC_W-1){1'b0}}, 1'b1};
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_ctrl.fire = w_fire;
    assign o_ctrl.word = w_word;

endmodule
`default_nettype wire

@@ hdl/lcdnib_dp.sv @@
`default_nettype none
module lcdnib_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [lcdnib_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lcdnib_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                  i_start,
    input  wire lcdnib_pkg::t_action                   i_action,
    input  wire logic                                  i_row,
    input  wire logic [5:0]                            i_column,
    input  wire logic [7:0]                            i_char_code,
    input  wire lcdnib_pkg::t_ctrl                     i_ctrl,
    output logic                                       o_slot_free,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic                                       o_rs,
    output logic [3:0]                                 o_data_nibble,
    output logic                                       o_enable,
    output logic [lcdnib_pkg::HOLD_W-1:0]              o_hold_us,
    output logic                                       o_last
);

    logic [lcdnib_pkg::PULSE_W-1:0] r_pulse_us;
    logic [lcdnib_pkg::HOLD_W-1:0]  r_pwrup_us;
    logic [lcdnib_pkg::HOLD_W-1:0]  r_clrwait_us;
    logic [lcdnib_pkg::HOLD_W-1:0]  r_step_us;
    logic [7:0]                     r_entry_mode;
    logic [7:0]                     r_disp_ctrl;

    logic [7:0]                     r_oper;
    logic                           r_oper_rs;
    logic [3:0]                     r_nib_level;

    logic                           r_out_valid;
    logic                           r_out_rs;
    logic [3:0]                     r_out_nib;
    logic                           r_out_en;
    logic [lcdnib_pkg::HOLD_W-1:0]  r_out_hold;
    logic                           r_out_last;

    logic [7:0]                     w_byte;
    logic [3:0]                     n_nib;
    logic [lcdnib_pkg::HOLD_W-1:0]  w_hold;
    logic [7:0]                     w_cursor;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_us   <= 10'd20;
            r_pwrup_us   <= 16'd50000;
            r_clrwait_us <= 16'd2000;
            r_step_us    <= 16'd1000;
            r_entry_mode <= 8'h06;
            r_disp_ctrl  <= 8'h0C;
        end else if (i_cfg_we) begin
            case (lcdnib_pkg::t_cfg_idx'(i_cfg_index))
                lcdnib_pkg::CFG_PULSE:   r_pulse_us   <= i_cfg_data[lcdnib_pkg::PULSE_W-1:0];
                lcdnib_pkg::CFG_PWRUP:   r_pwrup_us   <= i_cfg_data;
                lcdnib_pkg::CFG_CLRWAIT: r_clrwait_us <= i_cfg_data;
                lcdnib_pkg::CFG_STEP:    r_step_us    <= i_cfg_data;
                lcdnib_pkg::CFG_ENTRY:   r_entry_mode <= i_cfg_data[7:0];
                lcdnib_pkg::CFG_DISP:    r_disp_ctrl  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_cursor = (i_row ? lcdnib_pkg::ROW1_BASE : lcdnib_pkg::ROW0_BASE)
                    | {2'b00, i_column};

    // operand byte latched with the word
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_oper    <= (i_action == lcdnib_pkg::ACT_CURSOR) ? w_cursor : i_char_code;
            r_oper_rs <= (i_action == lcdnib_pkg::ACT_CHAR);
        end
    end

    always_comb begin
        case (i_ctrl.word.byte_sel)
            lcdnib_pkg::BYTE_FSET:  w_byte = lcdnib_pkg::CMD_FUNCTION_SET;
            lcdnib_pkg::BYTE_DOFF:  w_byte = lcdnib_pkg::CMD_DISPLAY_OFF;
            lcdnib_pkg::BYTE_CLR:   w_byte = lcdnib_pkg::CMD_CLEAR;
            lcdnib_pkg::BYTE_ENTRY: w_byte = r_entry_mode;
            lcdnib_pkg::BYTE_DISP:  w_byte = r_disp_ctrl;
            default:                w_byte = r_oper;
        endcase
    end

    always_comb begin
        case (i_ctrl.word.nib)
            lcdnib_pkg::NIB_HI:   n_nib = w_byte[7:4];
            lcdnib_pkg::NIB_LO:   n_nib = w_byte[3:0];
            lcdnib_pkg::NIB_WAKE: n_nib = lcdnib_pkg::WAKE_NIBBLE;
            lcdnib_pkg::NIB_FOUR: n_nib = lcdnib_pkg::FOUR_BIT_NIBBLE;
            default:              n_nib = r_nib_level;
        endcase
    end

    always_comb begin
        case (i_ctrl.word.hold)
            lcdnib_pkg::HOLD_PWRUP: w_hold = r_pwrup_us;
            lcdnib_pkg::HOLD_FIRST: w_hold = lcdnib_pkg::FIRST_INIT_WAIT_US;
            lcdnib_pkg::HOLD_STEP:  w_hold = r_step_us;
            lcdnib_pkg::HOLD_CLEAR: w_hold = r_clrwait_us;
            default: w_hold = {{(lcdnib_pkg::HOLD_W-lcdnib_pkg::PULSE_W){1'b0}}, r_pulse_us};
        endcase
    end

    // data line levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nib_level <= 4'h0;
        end else if (i_ctrl.fire) begin
            r_nib_level <= n_nib;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire) begin
            r_out_rs   <= r_oper_rs;
            r_out_nib  <= n_nib;
            r_out_en   <= i_ctrl.word.en;
            r_out_hold <= w_hold;
            r_out_last <= i_ctrl.word.last;
        end
    end

    assign o_slot_free   = !r_out_valid || i_ready;
    assign o_valid       = r_out_valid;
    assign o_rs          = r_out_rs;
    assign o_data_nibble = r_out_nib;
    assign o_enable      = r_out_en;
    assign o_hold_us     = r_out_hold;
    assign o_last        = r_out_last;

endmodule
`default_nettype wire

@@ hdl/char_lcd_nibble_bus_sequencer.sv @@
`default_nettype none
// Character LCD 4-bit bus sequencer. Each accepted word names one action (init, set cursor,
// clear, write character) and is answered by a run of pin-state words (rs, D7..D4, enable,
// hold time in microseconds), the final one flagged with o_last: init gives 38 words, clear 5,
// set cursor and write character 4 each. The pin states come from a microcode table walked by
// a step counter, one word per clock while the output side takes them; a new action is taken
// only once the previous run has been fully issued. The data lines keep their level across
// actions. Configuration registers are written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write them only while the block is idle, which the block does not enforce.
module char_lcd_nibble_bus_sequencer (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [lcdnib_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lcdnib_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [1:0]                            i_action,
    input  wire logic                                  i_row,
    input  wire logic [5:0]                            i_column,
    input  wire logic [7:0]                            i_char_code,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic                                       o_rs,
    output logic [3:0]                                 o_data_nibble,
    output logic                                       o_enable,
    output logic [lcdnib_pkg::HOLD_W-1:0]              o_hold_us,
    output logic                                       o_last
);

    logic                   w_busy;
    logic                   w_start;
    logic                   w_slot_free;
    lcdnib_pkg::t_action    w_action;
    lcdnib_pkg::t_ctrl      w_ctrl;

    assign w_action = lcdnib_pkg::t_action'(i_action);
    assign o_ready  = !w_busy;
    assign w_start  = i_valid && !w_busy;

    lcdnib_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_action    (w_action),
        .i_slot_free (w_slot_free),
        .o_busy      (w_busy),
        .o_ctrl      (w_ctrl)
    );

    lcdnib_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start       (w_start),
        .i_action      (w_action),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_char_code   (i_char_code),
        .i_ctrl        (w_ctrl),
        .o_slot_free   (w_slot_free),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_rs          (o_rs),
        .o_data_nibble (o_data_nibble),
        .o_enable      (o_enable),
        .o_hold_us     (o_hold_us),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

@@ verif/char_lcd_nibble_bus_sequencer_tb.sv @@
`default_nettype none
module char_lcd_nibble_bus_sequencer_tb;

    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic                          rs;
        logic [3:0]                    nib;
        logic                          en;
        logic [lcdnib_pkg::HOLD_W-1:0] hold;
        logic                          last;
    } t_pin;

    // tracks the bus level and the pin states each accepted action must produce
    class lcd_pin_scoreboard;
        logic [lcdnib_pkg::PULSE_W-1:0] pulse_us;
        logic [lcdnib_pkg::HOLD_W-1:0]  pwrup_us;
        logic [lcdnib_pkg::HOLD_W-1:0]  clr_us;
        logic [lcdnib_pkg::HOLD_W-1:0]  step_us;
        logic [7:0]                     entry_cmd;
        logic [7:0]                     disp_cmd;
        logic [3:0]                     bus_level;
        t_pin                           pending_pins[$];
        int                             errors;
        int                             pins_seen;

        function new();
            pulse_us  = 10'd20;
            pwrup_us  = 16'd50000;
            clr_us    = 16'd2000;
            step_us   = 16'd1000;
            entry_cmd = 8'h06;
            disp_cmd  = 8'h0C;
            bus_level = 4'h0;
            errors    = 0;
            pins_seen = 0;
        endfunction

        function void set_reg(logic [lcdnib_pkg::CFG_IDX_W-1:0] idx,
                              logic [lcdnib_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lcdnib_pkg::CFG_PULSE:   pulse_us  = data[lcdnib_pkg::PULSE_W-1:0];
                lcdnib_pkg::CFG_PWRUP:   pwrup_us  = data;
                lcdnib_pkg::CFG_CLRWAIT: clr_us    = data;
                lcdnib_pkg::CFG_STEP:    step_us   = data;
                lcdnib_pkg::CFG_ENTRY:   entry_cmd = data[7:0];
                lcdnib_pkg::CFG_DISP:    disp_cmd  = data[7:0];
                default: ;
            endcase
        endfunction

        function void add_state(logic rs, logic en, logic [lcdnib_pkg::HOLD_W-1:0] hold);
            t_pin p;
            p.rs   = rs;
            p.nib  = bus_level;
            p.en   = en;
            p.hold = hold;
            p.last = 1'b0;
            pending_pins.push_back(p);
        endfunction

        function void add_nibble(logic rs, logic [3:0] n);
            bus_level = n;
            add_state(rs, 1'b1, {{(lcdnib_pkg::HOLD_W-lcdnib_pkg::PULSE_W){1'b0}}, pulse_us});
            add_state(rs, 1'b0, {{(lcdnib_pkg::HOLD_W-lcdnib_pkg::PULSE_W){1'b0}}, pulse_us});
        endfunction

        function void add_byte(logic rs, logic [7:0] b);
            add_nibble(rs, b[7:4]);
            add_nibble(rs, b[3:0]);
        endfunction

        function void note_action(lcdnib_pkg::t_action act, logic row, logic [5:0] col,
                                  logic [7:0] ch);
            case (act)
                lcdnib_pkg::ACT_INIT: begin
                    add_state(1'b0, 1'b0, pwrup_us);
                    add_nibble(1'b0, lcdnib_pkg::WAKE_NIBBLE);
                    add_state(1'b0, 1'b0, lcdnib_pkg::FIRST_INIT_WAIT_US);
                    add_nibble(1'b0, lcdnib_pkg::WAKE_NIBBLE);
                    add_state(1'b0, 1'b0, step_us);
                    add_nibble(1'b0, lcdnib_pkg::WAKE_NIBBLE);
                    add_state(1'b0, 1'b0, step_us);
                    add_nibble(1'b0, lcdnib_pkg::FOUR_BIT_NIBBLE);
                    add_state(1'b0, 1'b0, step_us);
                    add_byte(1'b0, lcdnib_pkg::CMD_FUNCTION_SET);
                    add_state(1'b0, 1'b0, step_us);
                    add_byte(1'b0, lcdnib_pkg::CMD_DISPLAY_OFF);
                    add_state(1'b0, 1'b0, step_us);
                    add_byte(1'b0, lcdnib_pkg::CMD_CLEAR);
                    add_state(1'b0, 1'b0, clr_us);
                    add_byte(1'b0, entry_cmd);
                    add_state(1'b0, 1'b0, step_us);
                    add_byte(1'b0, disp_cmd);
                    add_state(1'b0, 1'b0, step_us);
                end
                lcdnib_pkg::ACT_CURSOR: begin
                    add_byte(1'b0, (row ? lcdnib_pkg::ROW1_BASE : lcdnib_pkg::ROW0_BASE)
                                   | {2'b00, col});
                end
                lcdnib_pkg::ACT_CLEAR: begin
                    add_byte(1'b0, lcdnib_pkg::CMD_CLEAR);
                    add_state(1'b0, 1'b0, clr_us);
                end
                default: add_byte(1'b1, ch);
            endcase
            pending_pins[pending_pins.size()-1].last = 1'b1;
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pin(t_pin got);
            t_pin want;
            pins_seen++;
            if (pending_pins.size() == 0) begin
                $display("%0t: unexpected pin state, expected none actual", $time);
                $display("    rs=%0d nib=%0h en=%0d hold=%0d last=%0d",
                         got.rs, got.nib, got.en, got.hold, got.last);
                errors++;
            end else begin
                want = pending_pins.pop_front();
                field_check("rs", want.rs, got.rs);
                field_check("data_nibble", want.nib, got.nib);
                field_check("enable", want.en, got.en);
                field_check("hold_us", want.hold, got.hold);
                field_check("last", want.last, got.last);
            end
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [lcdnib_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lcdnib_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [1:0]                        i_action = '0;
    logic                              i_row = 1'b0;
    logic [5:0]                        i_column = '0;
    logic [7:0]                        i_char_code = '0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic                              o_rs;
    logic [3:0]                        o_data_nibble;
    logic                              o_enable;
    logic [lcdnib_pkg::HOLD_W-1:0]     o_hold_us;
    logic                              o_last;

    lcd_pin_scoreboard sb;
    int sender_idle = 9;
    int receiver_idle = 57;
    int action_count[4] = '{0, 0, 0, 0};
    int reg_writes = 0;
    int unsigned cycles = 0;

    char_lcd_nibble_bus_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_char_code   (i_char_code),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_rs          (o_rs),
        .o_data_nibble (o_data_nibble),
        .o_enable      (o_enable),
        .o_hold_us     (o_hold_us),
        .o_last        (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_idle);
    end

    // everything the block sees or emits is sampled at the edge that moves it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.set_reg(i_cfg_index, i_cfg_data);
                reg_writes++;
            end
            if (i_valid && o_ready) begin
                sb.note_action(lcdnib_pkg::t_action'(i_action), i_row, i_column, i_char_code);
                action_count[i_action]++;
            end
            if (o_valid && i_ready)
                sb.check_pin(t_pin'({o_rs, o_data_nibble, o_enable, o_hold_us, o_last}));
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d pin states outstanding", $time,
                     sb.pending_pins.size());
            $display("char_lcd_nibble_bus_sequencer_tb: errors");
            $finish;
        end
    end

    task automatic send_action(input logic [1:0] act, input logic row, input logic [5:0] col,
                               input logic [7:0] ch);
        while ($urandom_range(99) < sender_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_row       <= row;
        i_column    <= col;
        i_char_code <= ch;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // drop valid and wait until every pin state owed has come out
    task automatic drain;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_pins.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input lcdnib_pkg::t_cfg_idx idx,
                             input logic [lcdnib_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [15:0] pulse, input logic [15:0] pwrup,
                                 input logic [15:0] clr, input logic [15:0] stp,
                                 input logic [15:0] entry, input logic [15:0] disp);
        drain();
        write_reg(lcdnib_pkg::CFG_PULSE, pulse);
        write_reg(lcdnib_pkg::CFG_PWRUP, pwrup);
        write_reg(lcdnib_pkg::CFG_CLRWAIT, clr);
        write_reg(lcdnib_pkg::CFG_STEP, stp);
        write_reg(lcdnib_pkg::CFG_ENTRY, entry);
        write_reg(lcdnib_pkg::CFG_DISP, disp);
        // indexes past the last register must be ignored
        write_reg(lcdnib_pkg::t_cfg_idx'(3'd6), 16'($urandom));
        write_reg(lcdnib_pkg::t_cfg_idx'(3'd7), 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n);
        repeat (n)
            send_action(2'($urandom_range(3)), 1'($urandom_range(1)), 6'($urandom_range(63)),
                        8'($urandom));
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under the reset settings
        send_action(lcdnib_pkg::ACT_INIT, 1'b0, 6'd0, 8'h00);
        send_action(lcdnib_pkg::ACT_CLEAR, 1'b1, 6'd63, 8'hFF);
        send_action(lcdnib_pkg::ACT_CURSOR, 1'b0, 6'd0, 8'hFF);
        send_action(lcdnib_pkg::ACT_CURSOR, 1'b1, 6'd39, 8'h00);
        send_action(lcdnib_pkg::ACT_CURSOR, 1'b0, 6'd63, 8'h5A);
        send_action(lcdnib_pkg::ACT_CURSOR, 1'b1, 6'd63, 8'hA5);
        send_action(lcdnib_pkg::ACT_CURSOR, 1'b0, 6'd40, 8'h00);
        send_action(lcdnib_pkg::ACT_CHAR, 1'b0, 6'd0, 8'h00);
        send_action(lcdnib_pkg::ACT_CHAR, 1'b1, 6'd63, 8'hFF);
        send_action(lcdnib_pkg::ACT_CHAR, 1'b1, 6'd21, 8'hA5);
        send_action(lcdnib_pkg::ACT_CHAR, 1'b0, 6'd42, 8'h5A);
        send_action(lcdnib_pkg::ACT_INIT, 1'b1, 6'd63, 8'hFF);
        send_action(lcdnib_pkg::ACT_CHAR, 1'b0, 6'd0, 8'h3C);
        send_action(lcdnib_pkg::ACT_CLEAR, 1'b0, 6'd0, 8'h00);
        send_action(lcdnib_pkg::ACT_INIT, 1'b0, 6'd0, 8'h00);

        // zero pulse and zero waits
        apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'h00, 16'h00);
        send_action(lcdnib_pkg::ACT_INIT, 1'b0, 6'd0, 8'h00);
        send_action(lcdnib_pkg::ACT_CHAR, 1'b0, 6'd0, 8'hC3);
        run_random(100);

        sender_idle = 57;
        receiver_idle = 9;
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_action(lcdnib_pkg::ACT_INIT, 1'b0, 6'd0, 8'h00);
        run_random(100);

        sender_idle = 0;
        receiver_idle = 0;
        apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
        run_random(100);

        apply_setting(16'd1, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom_range(255)), 16'($urandom_range(255)));
        run_random(100);

        drain();
        repeat (40) @(posedge i_clk);
        $display("actions: %0d init, %0d cursor, %0d clear, %0d char; %0d pin states checked",
                 action_count[lcdnib_pkg::ACT_INIT], action_count[lcdnib_pkg::ACT_CURSOR],
                 action_count[lcdnib_pkg::ACT_CLEAR], action_count[lcdnib_pkg::ACT_CHAR],
                 sb.pins_seen);
        $display("%0d register writes across min, max and random settings", reg_writes);
        if (sb.errors == 0)
            $display("char_lcd_nibble_bus_sequencer_tb: clean");
        else
            $display("char_lcd_nibble_bus_sequencer_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire
